>>> hw/rtl/rpn_pkg.sv
// Package for the RPN stack calculator: operation codes, Q16.16 constants, shared types.
// No dependencies.
`timescale 1ns / 1ps
package rpn_pkg;

  localparam int unsigned DefStackDepth = 64;
  localparam logic [31:0] PiQ16 = 32'd205887;
  localparam logic [15:0] CntMax = 16'hFFFF;

  localparam logic [3:0] OpPush = 4'd0;
  localparam logic [3:0] OpAdd  = 4'd1;
  localparam logic [3:0] OpSub  = 4'd2;
  localparam logic [3:0] OpMul  = 4'd3;
  localparam logic [3:0] OpDiv  = 4'd4;
  localparam logic [3:0] OpSqr  = 4'd5;
  localparam logic [3:0] OpNeg  = 4'd6;
  localparam logic [3:0] OpPi   = 4'd7;
  localparam logic [3:0] OpDup  = 4'd8;

  localparam logic [1:0] ErrNone    = 2'd0;
  localparam logic [1:0] ErrInvalid = 2'd1;
  localparam logic [1:0] ErrDivZero = 2'd2;
  localparam logic [1:0] ErrEmpty   = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_op;     // latch mode and operand
    logic pop_a;       // pop into register a
    logic pop_b;       // pop into register b
    logic compute;     // start the result computation
    logic push_res;    // push the result register
    logic push_a;      // push register a (duplicate)
    logic bump_inv;    // count an invalid token
    logic out_load;    // capture the output item
  } rpn_cmd_t;

  typedef struct packed {
    logic rd_wait;     // stack read still in flight
    logic res_ready;   // result valid in register
    logic res_push;    // result should be pushed
  } rpn_sts_t;

  function automatic logic [31:0] sat64(input logic signed [63:0] v);
    if (v > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
    if (v < -64'sh8000_0000) return 32'h8000_0000;
    return v[31:0];
  endfunction

endpackage

>>> hw/rtl/rpn_stream_if.sv
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
`timescale 1ns / 1ps
interface rpn_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/rpn_divider.sv
// Sequential signed divider for Q16.16: (a << 16) / b, truncated, saturated.
// Depends on rpn_pkg.
`timescale 1ns / 1ps
module rpn_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        done,
  output logic [31:0] q
);
  logic        busy;
  logic [5:0]  cnt;
  logic [47:0] quo;
  logic [31:0] rem;
  logic [31:0] den;
  logic        neg;
  logic [32:0] trial;
  logic [31:0] mag_a;
  logic [48:0] sq;

  assign mag_a = a[31] ? (~a + 32'd1) : a;
  assign trial = {rem, quo[47]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd0;
        quo  <= {mag_a, 16'd0};
        rem  <= 32'd0;
        den  <= b[31] ? (~b + 32'd1) : b;
        neg  <= a[31] ^ b[31];
      end else if (busy) begin
        // One restoring step per cycle, 48 quotient bits.
        if (!trial[32]) begin
          rem <= trial[31:0];
          quo <= {quo[46:0], 1'b1};
        end else begin
          rem <= {rem[30:0], quo[47]};
          quo <= {quo[46:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'd47) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign sq = neg ? -{1'b0, quo} : {1'b0, quo};
  assign q = rpn_pkg::sat64({{15{sq[48]}}, sq});
endmodule

>>> hw/rtl/rpn_datapath.sv
// Stack memory, operand registers, arithmetic and counters.
// Depends on rpn_pkg and rpn_divider.
`timescale 1ns / 1ps
module rpn_datapath #(
  parameter int unsigned StackDepth = rpn_pkg::DefStackDepth
) (
  input  logic             clk,
  input  logic             rst,
  input  rpn_pkg::rpn_cmd_t cmd,
  output rpn_pkg::rpn_sts_t sts,
  input  logic [3:0]       in_mode,
  input  logic [31:0]      in_operand,
  output logic [31:0]      o_top,
  output logic [6:0]       o_depth,
  output logic [1:0]       o_err,
  output logic [15:0]      o_unf,
  output logic [15:0]      o_dz,
  output logic [15:0]      o_inv,
  output logic [15:0]      o_ovf
);
  localparam int unsigned AW = $clog2(StackDepth);
  localparam int unsigned CW = $clog2(StackDepth + 1);

  logic [31:0] mem [StackDepth];
  logic [31:0] rdata;
  logic [31:0] top_reg;
  logic [CW-1:0] count;
  logic [3:0]  mode;
  logic [31:0] opnd;
  logic [31:0] ra, rb, res;
  logic        res_valid, res_push, rd_pend, rd_a;
  logic        rd_done;
  logic [1:0]  mul_stage;
  logic signed [63:0] prod;
  logic        div_start, div_done;
  logic [31:0] div_q;
  logic [15:0] unf, dz, inv, ovf;
  logic        full, empty;
  logic [CW-1:0] cm1;
  logic [31:0] push_val;
  logic        do_push;
  logic signed [63:0] addsub;
  logic [AW-1:0] waddr, raddr;

  assign full  = (count == CW'(StackDepth));
  assign empty = (count == '0);
  assign cm1   = count - CW'(1);
  assign waddr = count[AW-1:0];
  assign raddr = cm1[AW-1:0];
  assign do_push = cmd.push_res | cmd.push_a;
  assign push_val = cmd.push_a ? ra : res;

  rpn_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .a(ra), .b(rb),
    .done(div_done), .q(div_q)
  );

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (rst) mem[0] <= '0;
    else if (do_push && !full) mem[waddr] <= push_val;
  end

  always_comb begin
    if (mode == rpn_pkg::OpAdd) addsub = 64'($signed(ra)) + 64'($signed(rb));
    else if (mode == rpn_pkg::OpSub) addsub = 64'($signed(ra)) - 64'($signed(rb));
    else addsub = -64'($signed(ra));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= CW'(1);
      top_reg <= '0;
      unf <= '0; dz <= '0; inv <= '0; ovf <= '0;
      res_valid <= 1'b0; res_push <= 1'b0; rd_pend <= 1'b0;
      rd_done <= 1'b0;
      mul_stage <= '0; div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      rd_done <= rd_pend;
      if (cmd.load_op) begin
        mode <= in_mode;
        opnd <= in_operand;
        res_valid <= 1'b0;
      end
      if (cmd.bump_inv && inv != rpn_pkg::CntMax) inv <= inv + 16'd1;
      // Pop: the top entry is read into rdata, then copied into the operand register while rd_pend is set.
      if (cmd.pop_a || cmd.pop_b) begin
        if (empty) begin
          if (unf != rpn_pkg::CntMax) unf <= unf + 16'd1;
          if (cmd.pop_a) ra <= '0; else rb <= '0;
        end else begin
          count <= cm1;
          rd_pend <= 1'b1;
          rd_a <= cmd.pop_a;
        end
      end
      if (rd_pend) begin
        rd_pend <= 1'b0;
        if (rd_a) ra <= rdata; else rb <= rdata;
      end
      if (cmd.compute) begin
        res_push <= 1'b1;
        unique case (mode)
          rpn_pkg::OpPush: begin res <= opnd; res_valid <= 1'b1; end
          rpn_pkg::OpPi: begin res <= rpn_pkg::PiQ16; res_valid <= 1'b1; end
          rpn_pkg::OpAdd, rpn_pkg::OpSub, rpn_pkg::OpNeg: begin
            res <= rpn_pkg::sat64(addsub); res_valid <= 1'b1;
          end
          rpn_pkg::OpMul, rpn_pkg::OpSqr: mul_stage <= 2'd1;
          rpn_pkg::OpDiv: begin
            if ($signed(rb) <= -32'sd65536 || $signed(rb) >= 32'sd65536)
              div_start <= 1'b1;
            else begin
              res_push <= 1'b0; res_valid <= 1'b1;
              if (dz != rpn_pkg::CntMax) dz <= dz + 16'd1;
            end
          end
          default: begin res_push <= 1'b0; res_valid <= 1'b1; end
        endcase
      end
      if (mul_stage == 2'd1) begin
        prod <= $signed(ra) * ((mode == rpn_pkg::OpSqr) ? $signed(ra) : $signed(rb));
        mul_stage <= 2'd2;
      end else if (mul_stage == 2'd2) begin
        // Divide by 65536 truncating toward zero.
        res <= rpn_pkg::sat64((prod + (prod[63] ? 64'sd65535 : 64'sd0)) >>> 16);
        res_valid <= 1'b1;
        mul_stage <= '0;
      end
      if (div_done) begin res <= div_q; res_valid <= 1'b1; end
      if (do_push) begin
        if (full) begin
          if (ovf != rpn_pkg::CntMax) ovf <= ovf + 16'd1;
        end else begin
          count <= count + CW'(1);
          top_reg <= push_val;
        end
        if (cmd.push_res) res_valid <= 1'b0;
      end
      if (cmd.out_load) begin
        o_top   <= empty ? 32'd0 : (rd_pend ? rdata : top_reg);
        o_depth <= 7'(count);
      end
      // The entry below a popped one is on the read data in the cycle after the pop data.
      if (rd_done) top_reg <= rdata;
    end
  end

  assign sts.rd_wait   = rd_pend;
  assign sts.res_ready = res_valid;
  assign sts.res_push  = res_push;

  always_comb begin
    if (inv != '0) o_err = rpn_pkg::ErrInvalid;
    else if (dz != '0) o_err = rpn_pkg::ErrDivZero;
    else if (unf != '0) o_err = rpn_pkg::ErrEmpty;
    else o_err = rpn_pkg::ErrNone;
  end
  assign o_unf = unf;
  assign o_dz  = dz;
  assign o_inv = inv;
  assign o_ovf = ovf;
endmodule

>>> hw/rtl/rpn_controller.sv
// Sequencer for one operation: pops, compute, pushes, result capture.
// Depends on rpn_pkg.
`timescale 1ns / 1ps
module rpn_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [3:0]        in_mode,
  output logic              out_valid,
  input  logic              out_ready,
  output rpn_pkg::rpn_cmd_t cmd,
  input  rpn_pkg::rpn_sts_t sts
);
  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001, S_POPA = 10'b0000000010, S_WA = 10'b0000000100,
    S_POPB = 10'b0000001000, S_WB = 10'b0000010000, S_CALC = 10'b0000100000,
    S_WRES = 10'b0001000000, S_DUP = 10'b0010000000, S_OUT = 10'b0100000000,
    S_SEND = 10'b1000000000
  } state_t;

  state_t state, state_next;
  logic [3:0] mode;
  logic dup2;
  logic binop, unop;

  assign binop = (mode == rpn_pkg::OpAdd) || (mode == rpn_pkg::OpSub) ||
                 (mode == rpn_pkg::OpMul) || (mode == rpn_pkg::OpDiv);
  assign unop  = (mode == rpn_pkg::OpSqr) || (mode == rpn_pkg::OpNeg) ||
                 (mode == rpn_pkg::OpDup);

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_op = 1'b1;
          state_next = S_POPA;
        end
      end
      S_POPA: begin
        if (binop || unop) begin
          cmd.pop_a = 1'b1;
          state_next = S_WA;
        end else if (mode == rpn_pkg::OpPush || mode == rpn_pkg::OpPi) begin
          state_next = S_CALC;
        end else begin
          cmd.bump_inv = 1'b1;
          state_next = S_OUT;
        end
      end
      S_WA: if (!sts.rd_wait) begin
        if (binop) state_next = S_POPB;
        else if (mode == rpn_pkg::OpDup) state_next = S_DUP;
        else state_next = S_CALC;
      end
      S_POPB: begin cmd.pop_b = 1'b1; state_next = S_WB; end
      S_WB: if (!sts.rd_wait) state_next = S_CALC;
      S_CALC: begin cmd.compute = 1'b1; state_next = S_WRES; end
      S_WRES: if (sts.res_ready) begin
        cmd.push_res = sts.res_push;
        state_next = S_OUT;
      end
      S_DUP: begin
        cmd.push_a = 1'b1;
        if (dup2) state_next = S_OUT;
      end
      S_OUT: begin cmd.out_load = 1'b1; state_next = S_SEND; end
      S_SEND: begin
        out_valid = 1'b1;
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      dup2 <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DUP) dup2 <= ~dup2;
    end
    if (state == S_IDLE && in_valid) mode <= in_mode;
  end
endmodule

>>> hw/rtl/rpn_stack_calculator_core.sv
// Top level of the RPN stack calculator: controller, datapath, channels.
// Depends on rpn_pkg, rpn_stream_if, rpn_controller, rpn_datapath.
//
//  channel  dir  payload
//  in_ch    in   mode[3:0], operand[31:0]
//  out_ch   out  top_value, stack_depth, error_code, four counters
//
// One item at a time: push/pi skip the pops, binary ops pop two operands,
// multiply adds a product register, and divide waits on the 48-step divider.
// Synchronous reset leaves one zero on the stack and clears the counters.
// A stalled output holds the block; no new item is taken until it leaves.
`timescale 1ns / 1ps
module rpn_stack_calculator_core #(
  parameter int unsigned StackDepth = rpn_pkg::DefStackDepth
) (
  input logic clk,
  input logic rst,
  rpn_stream_if.sink   in_ch,
  rpn_stream_if.source out_ch
);
  rpn_pkg::rpn_cmd_t cmd;
  rpn_pkg::rpn_sts_t sts;

  rpn_controller u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_mode(in_ch.data.mode),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd(cmd), .sts(sts)
  );

  rpn_datapath #(.StackDepth(StackDepth)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .in_mode(in_ch.data.mode), .in_operand(in_ch.data.operand),
    .o_top(out_ch.data.top_value), .o_depth(out_ch.data.stack_depth),
    .o_err(out_ch.data.error_code), .o_unf(out_ch.data.underflow_count),
    .o_dz(out_ch.data.divide_zero_count), .o_inv(out_ch.data.invalid_count),
    .o_ovf(out_ch.data.overflow_count)
  );
endmodule
